// ----- sv/dmpc_pkg.sv -----
// ----------------------------------------------------------------------------
// dmpc_pkg
// Types and constants shared by the dual motor PWM controller and its
// channel interfaces.
// ----------------------------------------------------------------------------
package dmpc_pkg;

   // PWM period in ticks; a target at or above it keeps the pin on
   localparam int unsigned STEPS_PER_PERIOD = 100;

   localparam int unsigned NUM_CHANNELS = 4;
   localparam int unsigned NUM_MOTORS   = 2;
   localparam int unsigned NUM_CSR      = 2;

   localparam int unsigned PERCENT_W = 7;
   localparam int unsigned COUNT_W   = 8;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DAT_W = 8;

   localparam logic [PERCENT_W-1:0] TARGET_RESET = PERCENT_W'(100);
   localparam logic [COUNT_W-1:0]   COUNT_MAX    = '1;
   localparam logic [COUNT_W-1:0]   PERIOD_COUNT = COUNT_W'(STEPS_PER_PERIOD);

   typedef enum logic [2:0] {
      OP_TICK      = 3'd0,
      OP_SET_SPEED = 3'd1,
      OP_SET_DIR   = 3'd2,
      OP_RESET     = 3'd3,
      OP_TYPE_QRY  = 3'd4,
      OP_VER_QRY   = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      DIR_KEEP = 2'd0,
      DIR_CW   = 2'd1,
      DIR_CCW  = 2'd2,
      DIR_STOP = 2'd3
   } dir_type;

   typedef enum logic [1:0] {
      PH_OFF  = 2'd0,
      PH_HIGH = 2'd1,
      PH_LOW  = 2'd2
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FW_TYPE    = 1'd0,
      CSR_FW_VERSION = 1'd1
   } csr_idx_type;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] first_arg;
      logic [7:0] second_arg;
   } req_payload_type;

   typedef struct packed {
      logic [3:0] bridge_pins;
      logic [1:0] bridge_enables;
      logic       activity_led;
      logic       reply_valid;
      logic [7:0] reply_byte;
   } rsp_payload_type;

endpackage

// ----- sv/dmpc_if.sv -----
// ----------------------------------------------------------------------------
// dmpc_req_if / dmpc_rsp_if
// Valid/ready channels for commands in and status results out.
// ----------------------------------------------------------------------------
interface dmpc_req_if;
   logic                      valid;
   logic                      ready;
   dmpc_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface dmpc_rsp_if;
   logic                      valid;
   logic                      ready;
   dmpc_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/dual_motor_pwm_controller.sv -----
// ----------------------------------------------------------------------------
// dual_motor_pwm_controller
// Two H-bridges driven by four software PWM channels (M1A, M1B, M2A, M2B).
// Commands set speed, direction, reset the outputs or query firmware bytes;
// ticks advance the PWM phases. Every item yields one status result.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake      | payload
//  ----------+-----+----------------+-----------------------------------------
//  req_ch    | in  | valid/ready    | operation, first_arg, second_arg
//  rsp_ch    | out | valid/ready    | pins, enables, led, reply valid/byte
//  csr_*     | in  | write enable   | index 0 fw type, 1 fw version
//
//  A request passes through the input register, then the result register,
//  with the state update between them.
//  Sustained rate is one item per clock; the request side keeps taking
//  transfers while a result waits, stalling only when both stages are full.
//  Synchronous active-high reset: targets to 100%, all channels off,
//  pins, enables, LED and firmware bytes to zero.
// ----------------------------------------------------------------------------
module dual_motor_pwm_controller (
   input  logic                               clock,
   input  logic                               reset,
   dmpc_req_if.sink                           req_ch,
   dmpc_rsp_if.source                         rsp_ch,
   input  logic                               csr_we,
   input  logic [dmpc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dmpc_pkg::CSR_DAT_W-1:0]     csr_wdata
);

   localparam int unsigned NCH = dmpc_pkg::NUM_CHANNELS;

   // --- firmware bytes --------------------------------------------------------
   logic [7:0] fw_type_ff, fw_ver_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_type_ff <= '0;
         fw_ver_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            dmpc_pkg::CSR_FW_TYPE:    fw_type_ff <= csr_wdata;
            dmpc_pkg::CSR_FW_VERSION: fw_ver_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // --- input register --------------------------------------------------------
   logic                      s1_valid_ff, s1_valid_in;
   dmpc_pkg::req_payload_type s1_data_ff;
   logic                      req_xfer, s1_adv;

   logic                      rsp_valid_ff, rsp_valid_in;
   dmpc_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   // Stage 1 hands over whenever the result register is empty or draining.
   assign s1_adv       = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign req_xfer     = req_ch.valid && req_ch.ready;

   always_comb begin
      priority if (req_xfer) s1_valid_in = 1'b1;
      else if (s1_adv)       s1_valid_in = 1'b0;
      else                   s1_valid_in = s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= s1_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_xfer) s1_data_ff <= req_ch.payload;
   end

   // --- controller state ------------------------------------------------------
   logic [dmpc_pkg::PERCENT_W-1:0] target_ff [NCH];
   logic [dmpc_pkg::PERCENT_W-1:0] target_in [NCH];
   logic [dmpc_pkg::COUNT_W-1:0]   count_ff  [NCH];
   logic [dmpc_pkg::COUNT_W-1:0]   count_in  [NCH];
   dmpc_pkg::phase_type            phase_ff  [NCH];
   dmpc_pkg::phase_type            phase_in  [NCH];
   logic [NCH-1:0]                 pins_ff, pins_in;
   logic [1:0]                     en_ff, en_in;
   logic                           led_ff, led_in;

   always_comb begin
      logic [dmpc_pkg::COUNT_W-1:0] cnt_next;
      logic [1:0]                   dir_code;
      logic                         rep_valid;
      logic [7:0]                   rep_byte;

      target_in = target_ff;
      count_in  = count_ff;
      phase_in  = phase_ff;
      pins_in   = pins_ff;
      en_in     = en_ff;
      led_in    = led_ff;
      rep_valid = 1'b0;
      rep_byte  = '0;
      cnt_next  = '0;
      dir_code  = '0;

      unique case (s1_data_ff.operation)
         dmpc_pkg::OP_TICK: begin
            for (int c = 0; c < NCH; c++) begin
               if (phase_ff[c] != dmpc_pkg::PH_OFF) begin
                  // saturating step count
                  cnt_next = (count_ff[c] == dmpc_pkg::COUNT_MAX) ?
                             count_ff[c] : count_ff[c] + 1'b1;
                  count_in[c] = cnt_next;
                  if (phase_ff[c] == dmpc_pkg::PH_HIGH &&
                      cnt_next >= {1'b0, target_ff[c]}) begin
                     // full-scale targets never drop the pin
                     if ({1'b0, target_ff[c]} < dmpc_pkg::PERIOD_COUNT)
                        pins_in[c] = 1'b0;
                     phase_in[c] = dmpc_pkg::PH_LOW;
                  end else if (phase_ff[c] == dmpc_pkg::PH_LOW &&
                               cnt_next >= dmpc_pkg::PERIOD_COUNT) begin
                     pins_in[c]  = 1'b1;
                     phase_in[c] = dmpc_pkg::PH_HIGH;
                     count_in[c] = '0;
                  end
               end
            end
         end
         dmpc_pkg::OP_SET_SPEED: begin
            // mask bit 3 selects channel 0 down to bit 0 for channel 3
            for (int c = 0; c < NCH; c++) begin
               if (s1_data_ff.second_arg[NCH-1-c])
                  target_in[c] = s1_data_ff.first_arg[dmpc_pkg::PERCENT_W-1:0];
            end
         end
         dmpc_pkg::OP_SET_DIR: begin
            for (int m = 0; m < dmpc_pkg::NUM_MOTORS; m++) begin
               dir_code = (m == 0) ? s1_data_ff.first_arg[3:2] : s1_data_ff.first_arg[1:0];
               if (dir_code != dmpc_pkg::DIR_KEEP) begin
                  for (int k = 0; k < 2; k++) begin
                     count_in[2*m+k] = '0;
                     phase_in[2*m+k] = dmpc_pkg::PH_OFF;
                     pins_in[2*m+k]  = 1'b0;
                  end
                  en_in[m] = 1'b0;
                  if (dir_code == dmpc_pkg::DIR_CW) begin
                     pins_in[2*m]  = 1'b1;
                     phase_in[2*m] = dmpc_pkg::PH_HIGH;
                     en_in[m]      = 1'b1;
                  end else if (dir_code == dmpc_pkg::DIR_CCW) begin
                     pins_in[2*m+1]  = 1'b1;
                     phase_in[2*m+1] = dmpc_pkg::PH_HIGH;
                     en_in[m]        = 1'b1;
                  end
               end
            end
         end
         dmpc_pkg::OP_RESET: begin
            // pins and targets are left as they are
            for (int c = 0; c < NCH; c++) begin
               count_in[c] = '0;
               phase_in[c] = dmpc_pkg::PH_OFF;
            end
            en_in  = '0;
            led_in = 1'b1;
         end
         dmpc_pkg::OP_TYPE_QRY: begin
            led_in    = !led_ff;
            rep_valid = 1'b1;
            rep_byte  = fw_type_ff;
         end
         dmpc_pkg::OP_VER_QRY: begin
            led_in    = !led_ff;
            rep_valid = 1'b1;
            rep_byte  = fw_ver_ff;
         end
         default: ;
      endcase

      rsp_data_in.bridge_pins    = pins_in;
      rsp_data_in.bridge_enables = en_in;
      rsp_data_in.activity_led   = led_in;
      rsp_data_in.reply_valid    = rep_valid;
      rsp_data_in.reply_byte     = rep_byte;
   end

   // State commits only when the item moves into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NCH; c++) begin
            target_ff[c] <= dmpc_pkg::TARGET_RESET;
            count_ff[c]  <= '0;
            phase_ff[c]  <= dmpc_pkg::PH_OFF;
         end
         pins_ff <= '0;
         en_ff   <= '0;
         led_ff  <= 1'b0;
      end else if (s1_adv) begin
         target_ff <= target_in;
         count_ff  <= count_in;
         phase_ff  <= phase_in;
         pins_ff   <= pins_in;
         en_ff     <= en_in;
         led_ff    <= led_in;
      end
   end

   // --- result register -------------------------------------------------------
   always_comb begin
      priority if (s1_adv)   rsp_valid_in = 1'b1;
      else if (rsp_ch.ready) rsp_valid_in = 1'b0;
      else                   rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (s1_adv) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   // --- assertions ------------------------------------------------------------
   // a stopped channel never holds a step count
   a_off_count_zero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff[0] != dmpc_pkg::PH_OFF || count_ff[0] == '0) &&
      (phase_ff[1] != dmpc_pkg::PH_OFF || count_ff[1] == '0) &&
      (phase_ff[2] != dmpc_pkg::PH_OFF || count_ff[2] == '0) &&
      (phase_ff[3] != dmpc_pkg::PH_OFF || count_ff[3] == '0))
      else $error("stopped channel with nonzero count");

   // the HIGH phase always drives its pin
   a_high_pin_on: assert property (@(posedge clock) disable iff (reset)
      (phase_ff[0] != dmpc_pkg::PH_HIGH || pins_ff[0]) &&
      (phase_ff[1] != dmpc_pkg::PH_HIGH || pins_ff[1]) &&
      (phase_ff[2] != dmpc_pkg::PH_HIGH || pins_ff[2]) &&
      (phase_ff[3] != dmpc_pkg::PH_HIGH || pins_ff[3]))
      else $error("HIGH phase with pin low");

   // a disabled bridge has both of its channels stopped
   a_disabled_motor_off: assert property (@(posedge clock) disable iff (reset)
      (en_ff[0] || (phase_ff[0] == dmpc_pkg::PH_OFF && phase_ff[1] == dmpc_pkg::PH_OFF)) &&
      (en_ff[1] || (phase_ff[2] == dmpc_pkg::PH_OFF && phase_ff[3] == dmpc_pkg::PH_OFF)))
      else $error("channel running on a disabled bridge");

   // request side stalls only when both stages are full and the sink holds off
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_ch.ready))
      else $error("request stalled with room in the pipeline");

   // a reply byte only accompanies a query answer
   a_reply_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.reply_valid) |-> (rsp_data_ff.reply_byte == '0))
      else $error("reply byte without query");

endmodule
